@@ src/gpcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the grid peak clamp filter.
// Depends on nothing; imported by grid_peak_clamp_filter.
package gpcf_pkg;

  localparam int CFG_BITS       = 11;
  localparam int CFG_INDEX_BITS = 2;
  localparam int POS_BITS       = 10;
  localparam int NUM_SLOTS      = 3;
  localparam int SLOT_BITS      = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;

  localparam logic [CFG_BITS-1:0] GRID_DIM_RESET = 11'd1024;

  typedef logic [SLOT_BITS-1:0] slot_idx_t;

endpackage

@@ src/grid_peak_clamp_filter.sv @@
`timescale 1ns / 1ps
// Grid peak clamp filter: four-neighbor clamp over a raster pixel stream.
// Depends on gpcf_pkg.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   input   | in_valid, in_stall, pixel_in               | in
//   output  | out_valid, out_stall, pixel_out, out_row,  | out
//           | out_col, run_last, grid_done               |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data  | in
//
// One pixel per cycle on all rows but the last, while the output is not stalled. There a
// pixel yields up to three results (two in most columns of a multi-row grid) and the single
// output register holds the input until its last result is taken.
// Line state is one memory of MAX_WIDTH entries {row above, row two above},
// one write and one read per transaction; results pass through the hold stage and the output slots.
// Synchronous reset clears control only; the line memory is not cleared.
// Output stall propagates back to in_stall through a one-item hold stage.
module grid_peak_clamp_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [PIXEL_BITS-1:0]              pixel_in,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [PIXEL_BITS-1:0]              pixel_out,
  output logic [gpcf_pkg::POS_BITS-1:0]      out_row,
  output logic [gpcf_pkg::POS_BITS-1:0]      out_col,
  output logic                               run_last,
  output logic                               grid_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gpcf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gpcf_pkg::CFG_BITS-1:0]      cfg_data
);
  import gpcf_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int EW = 2 * PIXEL_BITS;

  function automatic logic [PIXEL_BITS-1:0] clamp_cell(
    input logic [PIXEL_BITS-1:0] self,
    input logic [PIXEL_BITS-1:0] n0,
    input logic [PIXEL_BITS-1:0] n1,
    input logic [PIXEL_BITS-1:0] n2,
    input logic [PIXEL_BITS-1:0] n3,
    input logic [3:0]            has
  );
    logic [PIXEL_BITS-1:0] m0, m1, m2, m3, a, b, best;
    m0 = has[0] ? n0 : '0;
    m1 = has[1] ? n1 : '0;
    m2 = has[2] ? n2 : '0;
    m3 = has[3] ? n3 : '0;
    a = (m0 > m1) ? m0 : m1;
    b = (m2 > m3) ? m2 : m3;
    best = (a > b) ? a : b;
    return ((|has) && (best < self)) ? best : self;
  endfunction

  // configuration
  logic [CFG_BITS-1:0] grid_width, grid_height;
  logic                cfg_write, cfg_known;
  logic [WW-1:0]       w_eff;
  logic [HW-1:0]       h_eff;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_known = (cfg_index == REG_GRID_WIDTH) || (cfg_index == REG_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_DIM_RESET;
      grid_height <= GRID_DIM_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_GRID_WIDTH) grid_width <= cfg_data;
      if (cfg_index == REG_GRID_HEIGHT) grid_height <= cfg_data;
    end
  end

  always_comb begin
    if (grid_width == '0) w_eff = WW'(1);
    else if (32'(grid_width) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(grid_width);
    if (grid_height == '0) h_eff = HW'(1);
    else if (32'(grid_height) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(grid_height);
  end

  // input side
  logic [RW-1:0] row_pos, row_cur, row_pos_next;
  logic [CW-1:0] col_pos, col_cur, col_pos_next;
  logic          pos_bad, last_col, last_row, acc;
  logic          b_valid, b_move;
  logic [EW-1:0] mem [0:MAX_WIDTH-1];
  logic [EW-1:0] rdata, fwd_data, cur_in;
  logic          fwd_hit;

  assign pos_bad  = (WW'(col_pos) >= w_eff) || (HW'(row_pos) >= h_eff);
  assign row_cur  = pos_bad ? '0 : row_pos;
  assign col_cur  = pos_bad ? '0 : col_pos;
  assign last_col = (WW'(col_cur) == WW'(w_eff - 1'b1));
  assign last_row = (HW'(row_cur) == HW'(h_eff - 1'b1));
  assign in_stall = b_valid && !b_move;
  assign acc      = in_valid && !in_stall;
  assign cur_in   = fwd_hit ? fwd_data : rdata;

  always_comb begin
    col_pos_next = last_col ? '0 : CW'(col_cur + 1'b1);
    row_pos_next = row_cur;
    if (last_col) row_pos_next = last_row ? '0 : RW'(row_cur + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (cfg_write && cfg_known) begin
      row_pos <= '0;
      col_pos <= '0;
    end else if (acc) begin
      row_pos <= row_pos_next;
      col_pos <= col_pos_next;
    end
  end

  // line memory: entry = {row above, row two above}
  always_ff @(posedge clk) begin
    if (acc) begin
      mem[col_cur] <= {pixel_in, cur_in[EW-1:PIXEL_BITS]};
      rdata <= mem[col_pos_next];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (acc) begin
      fwd_hit <= (col_pos_next == col_cur);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) fwd_data <= {pixel_in, cur_in[EW-1:PIXEL_BITS]};
  end

  // hold stage
  logic [PIXEL_BITS-1:0] b_pix, b_cur_up, b_cur_old, b_prev_up, b_left_one, b_left_two;
  logic [RW-1:0]         b_row;
  logic [CW-1:0]         b_col;
  logic                  b_last_row, b_last_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (acc) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_pix      <= pixel_in;
      b_left_one <= b_pix;
      b_left_two <= b_left_one;
      b_prev_up  <= b_cur_up;
      b_cur_up   <= cur_in[EW-1:PIXEL_BITS];
      b_cur_old  <= cur_in[PIXEL_BITS-1:0];
      b_row      <= row_cur;
      b_col      <= col_cur;
      b_last_row <= last_row;
      b_last_col <= last_col;
    end
  end

  // results of the held pixel
  logic [PIXEL_BITS-1:0] r_pix  [0:NUM_SLOTS-1];
  logic [POS_BITS-1:0]   r_row  [0:NUM_SLOTS-1];
  logic [POS_BITS-1:0]   r_col  [0:NUM_SLOTS-1];
  logic                  r_done [0:NUM_SLOTS-1];
  slot_idx_t             r_n;
  logic                  row_ge1, row_ge2, col_ge1, col_ge2;
  logic [PIXEL_BITS-1:0] next_up;

  assign row_ge1 = (b_row != '0);
  assign row_ge2 = (b_row > RW'(1));
  assign col_ge1 = (b_col != '0);
  assign col_ge2 = (b_col > CW'(1));
  assign next_up = rdata[EW-1:PIXEL_BITS];

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      r_pix[k]  = '0;
      r_row[k]  = '0;
      r_col[k]  = '0;
      r_done[k] = 1'b0;
    end
    r_n = '0;
    if (row_ge1) begin
      r_pix[r_n] = clamp_cell(b_cur_up, next_up, b_pix, b_prev_up, b_cur_old,
                              {row_ge2, col_ge1, 1'b1, !b_last_col});
      r_row[r_n] = POS_BITS'(b_row - 1'b1);
      r_col[r_n] = POS_BITS'(b_col);
      r_n = r_n + 1'b1;
    end
    if (b_last_row && col_ge1) begin
      r_pix[r_n] = clamp_cell(b_left_one, b_pix, '0, b_left_two, b_prev_up,
                              {row_ge1, col_ge2, 1'b0, 1'b1});
      r_row[r_n] = POS_BITS'(b_row);
      r_col[r_n] = POS_BITS'(b_col - 1'b1);
      r_n = r_n + 1'b1;
    end
    if (b_last_row && b_last_col) begin
      r_pix[r_n]  = clamp_cell(b_pix, '0, '0, b_left_one, b_cur_up,
                               {row_ge1, col_ge1, 1'b0, 1'b0});
      r_row[r_n]  = POS_BITS'(b_row);
      r_col[r_n]  = POS_BITS'(b_col);
      r_done[r_n] = 1'b1;
      r_n = r_n + 1'b1;
    end
  end

  // output slots
  logic [PIXEL_BITS-1:0] c_pix  [0:NUM_SLOTS-1];
  logic [POS_BITS-1:0]   c_row  [0:NUM_SLOTS-1];
  logic [POS_BITS-1:0]   c_col  [0:NUM_SLOTS-1];
  logic                  c_done [0:NUM_SLOTS-1];
  logic                  c_valid, out_take, c_last, c_free;
  slot_idx_t             c_cnt, c_idx;

  assign c_last   = (c_idx == slot_idx_t'(c_cnt - 1'b1));
  assign out_take = c_valid && !out_stall;
  assign c_free   = !c_valid || (out_take && c_last);
  assign b_move   = b_valid && ((r_n == '0) || c_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      c_cnt   <= '0;
      c_idx   <= '0;
    end else if (b_move && (r_n != '0)) begin
      c_valid <= 1'b1;
      c_cnt   <= r_n;
      c_idx   <= '0;
    end else if (out_take) begin
      if (c_last) c_valid <= 1'b0;
      else c_idx <= c_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move && (r_n != '0)) begin
      c_pix  <= r_pix;
      c_row  <= r_row;
      c_col  <= r_col;
      c_done <= r_done;
    end
  end

  assign out_valid = c_valid;
  assign pixel_out = c_pix[c_idx];
  assign out_row   = c_row[c_idx];
  assign out_col   = c_col[c_idx];
  assign grid_done = c_done[c_idx];
  assign run_last  = c_last;

endmodule
